// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the ATA task-file builder RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Invariant at every edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

`endif

// ===== rtl/atatf_pkg.sv =====
// Shared types and constants for the ATA task-file command builder.
// No dependencies.
package atatf_pkg;

  localparam int SECTORS_PER_TRACK_DEF = 63;
  localparam int HEADS_DEF             = 16;

  // Width of the address part that CHS and LBA28 can reach
  localparam int LBA28_W = 28;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATAPI   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LBA     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE0   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE1   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE2   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE3   = 3'd6;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_DRIVE = 2'd1;
  localparam logic [1:0] STATUS_RANGE    = 2'd2;
  localparam logic [1:0] STATUS_NOT_ATA  = 2'd3;

  localparam logic [3:0] REG_NONE    = 4'd0;
  localparam logic [3:0] REG_COUNT0  = 4'd2;
  localparam logic [3:0] REG_LBA0    = 4'd3;
  localparam logic [3:0] REG_LBA1    = 4'd4;
  localparam logic [3:0] REG_LBA2    = 4'd5;
  localparam logic [3:0] REG_DEVSEL  = 4'd6;
  localparam logic [3:0] REG_COMMAND = 4'd7;
  localparam logic [3:0] REG_COUNT1  = 4'd8;
  localparam logic [3:0] REG_LBA3    = 4'd9;
  localparam logic [3:0] REG_LBA4    = 4'd10;
  localparam logic [3:0] REG_LBA5    = 4'd11;

  localparam logic [7:0] CMD_READ_PIO     = 8'h20;
  localparam logic [7:0] CMD_READ_PIO_EXT = 8'h24;
  localparam logic [7:0] DEVSEL_LBA       = 8'hE0;
  localparam logic [7:0] DEVSEL_CHS       = 8'hA0;

  typedef enum logic [1:0] {
    MODE_REJECT,
    MODE_LBA48,
    MODE_LBA28,
    MODE_CHS
  } mode_t;

  // One decoded request, ready for the write sequencer
  typedef struct packed {
    mode_t      mode;
    logic [1:0] status;
    logic       ch;
    logic [7:0] devsel;
    logic [7:0] count;
    logic [7:0] lba0;
    logic [7:0] lba1;
    logic [7:0] lba2;
    logic [7:0] lba3;
    logic [7:0] command;
  } cmd_t;

endpackage

// ===== rtl/atatf_seq.sv =====
// Task-file write sequencer: holds one decoded request, emits one beat per cycle while out_ready is high.
// Depends on atatf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module atatf_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  atatf_pkg::cmd_t  cmd,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             channel,
  output logic [3:0]       reg_index,
  output logic [7:0]       value,
  output logic             write_valid,
  output logic [1:0]       status,
  output logic             last
);

  localparam logic [3:0] STEP_DEVSEL  = 4'd0;
  localparam logic [3:0] STEP_COUNT1  = 4'd1;
  localparam logic [3:0] STEP_LBA3    = 4'd2;
  localparam logic [3:0] STEP_LBA4    = 4'd3;
  localparam logic [3:0] STEP_LBA5    = 4'd4;
  localparam logic [3:0] STEP_COUNT0  = 4'd5;
  localparam logic [3:0] STEP_LBA0    = 4'd6;
  localparam logic [3:0] STEP_LBA1    = 4'd7;
  localparam logic [3:0] STEP_LBA2    = 4'd8;
  localparam logic [3:0] STEP_COMMAND = 4'd9;

  logic            busy;
  logic [3:0]      step;
  logic [3:0]      step_next;
  atatf_pkg::cmd_t cur;
  logic            beat;
  logic            done;
  logic            short_mode;

  assign out_valid  = busy;
  assign beat       = out_valid && out_ready;
  assign done       = beat && last;
  assign cmd_ready  = !busy || done;
  assign short_mode = (cur.mode == atatf_pkg::MODE_LBA28) || (cur.mode == atatf_pkg::MODE_CHS);

  // LBA28 and CHS skip the high-order writes after devsel
  assign step_next = (step == STEP_DEVSEL && short_mode) ? STEP_COUNT0 : step + 4'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= STEP_DEVSEL;
    end else if (cmd_valid && cmd_ready) begin
      busy <= 1'b1;
      step <= STEP_DEVSEL;
    end else if (done) begin
      busy <= 1'b0;
    end else if (beat) begin
      step <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      cur <= cmd;
    end
  end

  always_comb begin
    channel     = cur.ch;
    write_valid = 1'b1;
    status      = atatf_pkg::STATUS_OK;
    last        = (step == STEP_COMMAND);
    reg_index   = atatf_pkg::REG_NONE;
    value       = 8'h00;
    if (cur.mode == atatf_pkg::MODE_REJECT) begin
      channel     = 1'b0;
      write_valid = 1'b0;
      status      = cur.status;
      last        = 1'b1;
    end else begin
      unique case (step)
        STEP_DEVSEL: begin
          reg_index = atatf_pkg::REG_DEVSEL;
          value     = cur.devsel;
        end
        STEP_COUNT1: begin
          reg_index = atatf_pkg::REG_COUNT1;
        end
        STEP_LBA3: begin
          reg_index = atatf_pkg::REG_LBA3;
          value     = cur.lba3;
        end
        STEP_LBA4: begin
          reg_index = atatf_pkg::REG_LBA4;
        end
        STEP_LBA5: begin
          reg_index = atatf_pkg::REG_LBA5;
        end
        STEP_COUNT0: begin
          reg_index = atatf_pkg::REG_COUNT0;
          value     = cur.count;
        end
        STEP_LBA0: begin
          reg_index = atatf_pkg::REG_LBA0;
          value     = cur.lba0;
        end
        STEP_LBA1: begin
          reg_index = atatf_pkg::REG_LBA1;
          value     = cur.lba1;
        end
        STEP_LBA2: begin
          reg_index = atatf_pkg::REG_LBA2;
          value     = cur.lba2;
        end
        STEP_COMMAND: begin
          reg_index = atatf_pkg::REG_COMMAND;
          value     = cur.command;
        end
        default: begin
          reg_index = atatf_pkg::REG_NONE;
          value     = 8'h00;
        end
      endcase
    end
  end

  `ASSERT_IMPLIES(a_reject_single, clk, rst, out_valid && !write_valid, last && status != atatf_pkg::STATUS_OK, "rejected request must end in one beat with an error status")
  `ASSERT_IMPLIES(a_write_ok, clk, rst, out_valid && write_valid, status == atatf_pkg::STATUS_OK, "register write carries an error status")
  `ASSERT_NEXT(a_no_gap, clk, rst, beat && !last, out_valid, "request dropped before its final beat")
  `ASSERT_NEXT(a_short_skip, clk, rst, beat && step == STEP_DEVSEL && short_mode, step == STEP_COUNT0, "short form did not skip the high-order writes")
  `ASSERT_ALWAYS(a_step_range, clk, rst, step <= STEP_COMMAND, "write step beyond the command")

endmodule

// ===== rtl/ata_taskfile_command_builder.sv =====
// ATA task-file command builder: checks a read request and emits its register writes.
// A request passes three pipeline stages (input, checks, cylinder) before it reaches the sequencer.
// Throughput is set by the sequencer, which gives one write per cycle while out_ready is high:
// ten writes for LBA48, six for LBA28 or CHS, one beat when rejected; the decode stages overlap it.
// Reset clears the stage valids, the sequencer and all configuration registers to 0.
module ata_taskfile_command_builder #(
  parameter int SECTORS_PER_TRACK = atatf_pkg::SECTORS_PER_TRACK_DEF,
  parameter int HEADS             = atatf_pkg::HEADS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [atatf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     drive,
  input  logic [7:0]                     sector_count,
  input  logic [31:0]                    start_address,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           channel,
  output logic [3:0]                     reg_index,
  output logic [7:0]                     value,
  output logic                           write_valid,
  output logic [1:0]                     status,
  output logic                           last
);

  localparam int AW = atatf_pkg::LBA28_W;
  localparam int RW = AW + 1;
  localparam int PW = AW + RW;
  localparam int SPT_SHIFT   = AW + $clog2(SECTORS_PER_TRACK);
  localparam int HEADS_SHIFT = AW + $clog2(HEADS);
  localparam logic [RW-1:0] SPT_RECIP = RW'(((64'd1 << SPT_SHIFT) + 64'(SECTORS_PER_TRACK)
                                            - 64'd1) / 64'(SECTORS_PER_TRACK));
  localparam logic [RW-1:0] HEADS_RECIP = RW'(((64'd1 << HEADS_SHIFT) + 64'(HEADS)
                                              - 64'd1) / 64'(HEADS));
  localparam int SECT_W = $clog2(SECTORS_PER_TRACK + 1);

  // Configuration
  logic [3:0]  present_mask;
  logic [3:0]  atapi_mask;
  logic [3:0]  lba_mask;
  logic [31:0] drive_size [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      present_mask <= 4'h0;
      atapi_mask   <= 4'h0;
      lba_mask     <= 4'h0;
      for (int i = 0; i < 4; i++) begin
        drive_size[i] <= 32'h0;
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        atatf_pkg::CFG_PRESENT: present_mask  <= cfg_data[3:0];
        atatf_pkg::CFG_ATAPI:   atapi_mask    <= cfg_data[3:0];
        atatf_pkg::CFG_LBA:     lba_mask      <= cfg_data[3:0];
        atatf_pkg::CFG_SIZE0:   drive_size[0] <= cfg_data;
        atatf_pkg::CFG_SIZE1:   drive_size[1] <= cfg_data;
        atatf_pkg::CFG_SIZE2:   drive_size[2] <= cfg_data;
        atatf_pkg::CFG_SIZE3:   drive_size[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage handshake: a stage loads when empty or when its contents move on
  logic v1, v2, v3;
  logic r1, r2, r3;
  logic seq_ready;

  assign r3       = !v3 || seq_ready;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_ready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
    end
  end

  // Stage 1: input register
  logic [7:0]  s1_drive;
  logic [7:0]  s1_cnt;
  logic [31:0] s1_addr;

  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      s1_drive <= drive;
      s1_cnt   <= sector_count;
      s1_addr  <= start_address;
    end
  end

  // Stage 2: checks, mode, address / sectors-per-track
  logic [1:0]       d;
  logic             no_drive;
  logic             over;
  logic [32:0]      end_addr;
  logic [1:0]       chk_status;
  atatf_pkg::mode_t chk_mode;
  logic [PW-1:0]    t_prod;
  logic [PW-1:0]    t_quot;

  assign d        = s1_drive[1:0];
  assign no_drive = (|s1_drive[7:2]) || !present_mask[d];
  assign end_addr = {1'b0, s1_addr} + 33'(s1_cnt);
  assign over     = end_addr > {1'b0, drive_size[d]};
  assign t_prod   = PW'(s1_addr[AW-1:0]) * PW'(SPT_RECIP);
  assign t_quot   = t_prod >> SPT_SHIFT;

  always_comb begin
    chk_status = atatf_pkg::STATUS_OK;
    if (no_drive) begin
      chk_status = atatf_pkg::STATUS_NO_DRIVE;
    end else if (atapi_mask[d]) begin
      chk_status = atatf_pkg::STATUS_NOT_ATA;
    end else if (over) begin
      chk_status = atatf_pkg::STATUS_RANGE;
    end
    if (chk_status != atatf_pkg::STATUS_OK) begin
      chk_mode = atatf_pkg::MODE_REJECT;
    end else if (|s1_addr[31:AW]) begin
      chk_mode = atatf_pkg::MODE_LBA48;
    end else if (lba_mask[d]) begin
      chk_mode = atatf_pkg::MODE_LBA28;
    end else begin
      chk_mode = atatf_pkg::MODE_CHS;
    end
  end

  atatf_pkg::mode_t s2_mode;
  logic [1:0]       s2_status;
  logic             s2_ch;
  logic             s2_slave;
  logic [7:0]       s2_cnt;
  logic [31:0]      s2_addr;
  logic [AW-1:0]    s2_t;

  always_ff @(posedge clk) begin
    if (r2 && v1) begin
      s2_mode   <= chk_mode;
      s2_status <= chk_status;
      s2_ch     <= s1_drive[1];
      s2_slave  <= s1_drive[0];
      s2_cnt    <= s1_cnt;
      s2_addr   <= s1_addr;
      s2_t      <= t_quot[AW-1:0];
    end
  end

  // Stage 3: cylinder = track / heads, low bits of track * sectors-per-track
  logic [PW-1:0] cyl_prod;
  logic [PW-1:0] cyl_quot;
  logic [15:0]   p_full;

  assign cyl_prod = PW'(s2_t) * PW'(HEADS_RECIP);
  assign cyl_quot = cyl_prod >> HEADS_SHIFT;
  assign p_full   = 16'(s2_t[SECT_W-1:0]) * 16'(SECTORS_PER_TRACK);

  atatf_pkg::mode_t s3_mode;
  logic [1:0]       s3_status;
  logic             s3_ch;
  logic             s3_slave;
  logic [7:0]       s3_cnt;
  logic [31:0]      s3_addr;
  logic [3:0]       s3_t4;
  logic [15:0]      s3_cyl;
  logic [SECT_W-1:0] s3_p;

  always_ff @(posedge clk) begin
    if (r3 && v2) begin
      s3_mode   <= s2_mode;
      s3_status <= s2_status;
      s3_ch     <= s2_ch;
      s3_slave  <= s2_slave;
      s3_cnt    <= s2_cnt;
      s3_addr   <= s2_addr;
      s3_t4     <= s2_t[3:0];
      s3_cyl    <= cyl_quot[15:0];
      s3_p      <= p_full[SECT_W-1:0];
    end
  end

  // Build the decoded request; remainders are small, so work in low bits only
  logic [SECT_W-1:0] sect;
  logic [7:0]        hp;
  logic [3:0]        head;
  logic [7:0]        slave_bit;
  atatf_pkg::cmd_t   cmd;

  assign sect      = s3_addr[SECT_W-1:0] - s3_p + SECT_W'(1);
  assign hp        = 8'(s3_cyl[3:0]) * 8'(HEADS);
  assign head      = s3_t4 - hp[3:0];
  assign slave_bit = {3'b000, s3_slave, 4'b0000};

  always_comb begin
    cmd.mode    = s3_mode;
    cmd.status  = s3_status;
    cmd.ch      = s3_ch;
    cmd.count   = s3_cnt;
    cmd.lba3    = s3_addr[31:24];
    cmd.lba0    = s3_addr[7:0];
    cmd.lba1    = s3_addr[15:8];
    cmd.lba2    = s3_addr[23:16];
    cmd.command = atatf_pkg::CMD_READ_PIO;
    cmd.devsel  = atatf_pkg::DEVSEL_LBA | slave_bit;
    unique case (s3_mode)
      atatf_pkg::MODE_LBA48: begin
        cmd.command = atatf_pkg::CMD_READ_PIO_EXT;
      end
      atatf_pkg::MODE_LBA28: begin
        cmd.devsel = atatf_pkg::DEVSEL_LBA | slave_bit | {4'h0, s3_addr[27:24]};
      end
      atatf_pkg::MODE_CHS: begin
        cmd.devsel = atatf_pkg::DEVSEL_CHS | slave_bit | {4'h0, head};
        cmd.lba0   = 8'(sect);
        cmd.lba1   = s3_cyl[7:0];
        cmd.lba2   = s3_cyl[15:8];
      end
      default: begin
        cmd.devsel = 8'h00;
      end
    endcase
  end

  atatf_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (v3),
    .cmd_ready   (seq_ready),
    .cmd         (cmd),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .channel     (channel),
    .reg_index   (reg_index),
    .value       (value),
    .write_valid (write_valid),
    .status      (status),
    .last        (last)
  );

endmodule
